>>> rtl/dtc_pkg.sv
// dtc_pkg: shared types, constants and calendar helper functions for the
// date and time checker. No dependencies.
package dtc_pkg;

  // field widths
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned YoffW   = 7;
  localparam int unsigned SumW    = 8;

  // calendar limits
  localparam logic [YearW-1:0]   YearFirst = 12'd2000;
  localparam logic [YearW-1:0]   YearLast  = 12'd2099;
  localparam logic [MonthW-1:0]  MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0]  MonthDec  = 4'd12;
  localparam logic [HourW-1:0]   HourLim   = 5'd24;
  localparam logic [MinuteW-1:0] MinuteLim = 6'd60;
  localparam logic [SecondW-1:0] SecondLim = 6'd60;
  localparam logic [YoffW-1:0]   YoffMax   = 7'd99;
  localparam logic [WdayW-1:0]   WdaySun   = 3'd7;

  // input transaction payload
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } dtc_in_t;

  // result transaction payload
  typedef struct packed {
    logic             date_ok;
    logic             time_ok;
    logic [WdayW-1:0] weekday;
    logic [YoffW-1:0] year_offset;
  } dtc_out_t;

  // last day of the month, february grows by one in a leap year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // month term (26*m - 2)/10 of the congruence, march counted as m = 1
  function automatic logic [DayW-1:0] month_term(input logic [MonthW-1:0] month);
    logic [DayW-1:0] t;
    unique case (month)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // remainder by seven, folding octal digits since 8 is 1 modulo 7
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] v);
    logic [4:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    f1 = 5'(v[7:6]) + 5'(v[5:3]) + 5'(v[2:0]);
    f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
    f3 = (f2 >= 4'd7) ? f2 - 4'd7 : f2;
    return f3[WdayW-1:0];
  endfunction

endpackage

>>> rtl/dtc_in_if.sv
// dtc_in_if: valid/ready channel that carries one date and time transaction.
// Depends on dtc_pkg for the field widths.
interface dtc_in_if import dtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

>>> rtl/dtc_out_if.sv
// dtc_out_if: valid/ready channel that carries one check result transaction.
// Depends on dtc_pkg for the field widths.
interface dtc_out_if import dtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             date_ok;
  logic             time_ok;
  logic [WdayW-1:0] weekday;
  logic [YoffW-1:0] year_offset;

  modport source (output valid, date_ok, time_ok, weekday, year_offset, input ready);
  modport sink   (input valid, date_ok, time_ok, weekday, year_offset, output ready);
endinterface

>>> rtl/date_time_check_weekday.sv
// date_time_check_weekday: top level of the date and time checker.
// Depends on dtc_pkg, dtc_in_if and dtc_out_if.
//
// Takes one date and time transaction per cycle while not stalled and returns
// one result transaction for each: date_ok (year 2000..2099, month 1..12, day
// within the month, leap february every fourth year), time_ok (hour < 24,
// minute < 60, second < 60), the weekday 1 = Monday .. 7 = Sunday and the year
// offset from 2000, the last two zero for an invalid date. Throughput is one
// transaction per cycle while the result is taken. The input register captures
// a transaction when it is accepted and the result register captures the check
// from the input register once the result register is free. The whole check
// sits between the two registers. The input side stalls only while both
// registers are full and the result is not taken.
module date_time_check_weekday import dtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtc_in_if.sink     in_i,
  dtc_out_if.source  out_o
);

  logic     in_vld_q, in_vld_d;
  dtc_in_t  in_q, in_d;
  logic     out_vld_q, out_vld_d;
  dtc_out_t out_q, out_d;
  logic     out_adv;
  logic     in_adv;

  // pipeline advance
  assign out_adv   = !out_vld_q || out_o.ready;
  assign in_adv    = !in_vld_q || out_adv;
  assign in_i.ready = in_adv;

  assign in_vld_d  = in_adv ? in_i.valid : in_vld_q;
  assign out_vld_d = out_adv ? in_vld_q : out_vld_q;

  // input register payload
  always_comb begin
    in_d = in_q;
    if (in_adv && in_i.valid) begin
      in_d.year   = in_i.year;
      in_d.month  = in_i.month;
      in_d.day    = in_i.day;
      in_d.hour   = in_i.hour;
      in_d.minute = in_i.minute;
      in_d.second = in_i.second;
    end
  end

  // date check and weekday
  logic             year_ok, month_ok, day_ok, date_ok, early;
  logic [YearW-1:0] year_diff;
  logic [YoffW-1:0] yoff, yy;
  logic             cent_term;
  logic [SumW-1:0]  sum;
  logic [WdayW-1:0] rem;
  dtc_out_t         res;

  always_comb begin
    year_ok   = (in_q.year >= YearFirst) && (in_q.year <= YearLast);
    month_ok  = (in_q.month != '0) && (in_q.month <= MonthDec);
    year_diff = in_q.year - YearFirst;
    yoff      = year_diff[YoffW-1:0];
    day_ok    = (in_q.day != '0) && (in_q.day <= month_len(in_q.month, yoff[1:0] == 2'b00));
    date_ok   = year_ok && month_ok && day_ok;
    // january and february count with the previous year
    early     = (in_q.month <= MonthFeb);
    cent_term = early && (yoff == '0);
    if (!early) begin
      yy = yoff;
    end else if (yoff == '0) begin
      yy = YoffMax;
    end else begin
      yy = yoff - 7'd1;
    end
    // century terms are 0 mod 7 for 20xx and 1 mod 7 for 1999
    sum = SumW'(in_q.day) + SumW'(month_term(in_q.month)) + SumW'(yy)
        + SumW'(yy[YoffW-1:2]) + SumW'(cent_term);
    rem = mod7(sum);

    res.date_ok     = date_ok;
    res.time_ok     = (in_q.hour < HourLim) && (in_q.minute < MinuteLim)
                   && (in_q.second < SecondLim);
    res.weekday     = date_ok ? ((rem == '0) ? WdaySun : rem) : '0;
    res.year_offset = date_ok ? yoff : '0;
  end

  assign out_d = (out_adv && in_vld_q) ? res : out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.date_ok     = out_q.date_ok;
  assign out_o.time_ok     = out_q.time_ok;
  assign out_o.weekday     = out_q.weekday;
  assign out_o.year_offset = out_q.year_offset;

endmodule

>>> rtl/dtc_checker.sv
// dtc_checker: port level assertions for date_time_check_weekday, bound to it.
// Depends on dtc_pkg and the top level's interface ports.
module dtc_checker import dtc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             date_ok_i,
  input logic [WdayW-1:0] weekday_i,
  input logic [YoffW-1:0] year_offset_i
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  // invalid date gives zero weekday and offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !date_ok_i |-> weekday_i == '0 && year_offset_i == '0)
    else $error("date fields nonzero for invalid date");

  // valid date gives a real weekday and a two digit offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && date_ok_i |-> weekday_i != '0 && year_offset_i <= YoffMax)
    else $error("weekday or offset out of range for valid date");

  // input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without result backpressure");

endmodule

bind date_time_check_weekday dtc_checker u_dtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .date_ok_i     (out_o.date_ok),
  .weekday_i     (out_o.weekday),
  .year_offset_i (out_o.year_offset)
);
